[rtl/core/gost_pkg.sv]
`timescale 1ns / 1ps
// gost_pkg: shared types, codes and the round function of the gost block cipher engine
// no dependencies

package gost_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned NUM_ROWS = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned ROT_L    = 11;

  localparam logic [WORD_W-1:0] GAMMA_ADD_LOW  = 32'h0101_0101;
  localparam logic [WORD_W-1:0] GAMMA_ADD_HIGH = 32'h0101_0104;

  // last round index for the full cipher and for the mac transform
  localparam logic [4:0] LAST_ROUND_FULL = 5'd31;
  localparam logic [4:0] LAST_ROUND_MAC  = 5'd15;
  // positions from here on take the key words in reverse order
  localparam logic [4:0] REVERSE_START   = 5'd24;

  typedef enum logic [1:0] {
    FUNC_ENCRYPT = 2'd0,
    FUNC_DECRYPT = 2'd1,
    FUNC_MAC     = 2'd2,
    FUNC_GAMMA   = 2'd3
  } func_t;

  typedef logic [NUM_ROWS-1:0][BLOCK_W-1:0] sbox_rows_t;
  typedef logic [7:0][WORD_W-1:0]           key_words_t;

  // add key, substitute each nibble through its row, rotate left by 11
  function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] half,
                                                 input logic [WORD_W-1:0] key,
                                                 input sbox_rows_t rows);
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] sub;
    logic [NIB_W-1:0]  nib;
    sum = half + key;
    sub = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      nib = sum[NIB_W*i +: NIB_W];
      sub[NIB_W*i +: NIB_W] = rows[i][NIB_W*nib +: NIB_W];
    end
    return {sub[WORD_W-ROT_L-1:0], sub[WORD_W-1:WORD_W-ROT_L]};
  endfunction

endpackage

[rtl/core/gost_block_cipher_engine_top.sv]
`timescale 1ns / 1ps
// gost 28147-89 block cipher engine: one round unit reused under a small sequencer
// depends on gost_pkg
//
// rounds: encrypt, decrypt and gamma run 32 rounds, the mac transform 16 rounds, on the
//   single round unit doing one feistel round per cycle, then a flush state loads the
//   result into the output register
// a new transaction is taken only in the idle state, so input is not ready while rounds
//   run, and the flush waits as long as the output register still holds an unaccepted
//   result
// the next item is taken while a finished result still waits in the output register
// reset: synchronous active-high rst clears the sequencer, output valid and s-box rows

module gost_block_cipher_engine_top
  import gost_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_block[63:0], sync_value[127:64], key_words_0_1[191:128],
  // key_words_2_3[255:192], key_words_4_5[319:256], key_words_6_7[383:320]
  input  logic [383:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_block[63:0]
  output logic [63:0]  m_axis_tdata,
  // s-box row configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t            state;
  sbox_rows_t        sbox_rows;
  key_words_t        key_words;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] n2;
  logic [BLOCK_W-1:0] data_block;
  logic [4:0]        round_cnt;
  logic [4:0]        last_round;
  logic              decrypt;
  logic              gamma;
  logic [BLOCK_W-1:0] result;
  logic              result_valid;

  // input field views
  func_t              in_func;
  logic [BLOCK_W-1:0] in_data;
  logic [BLOCK_W-1:0] in_sync;

  assign in_func = func_t'(s_axis_tuser);
  assign in_data = s_axis_tdata[63:0];
  assign in_sync = s_axis_tdata[127:64];

  // gamma advance: low word mod 2^32, high word with end-around carry (mod 2^32-1)
  logic [WORD_W-1:0] adv_lo;
  logic [WORD_W:0]   adv_hi_sum;
  logic [WORD_W-1:0] adv_hi;

  assign adv_lo     = in_sync[WORD_W-1:0] + GAMMA_ADD_LOW;
  assign adv_hi_sum = {1'b0, in_sync[BLOCK_W-1:WORD_W]} + {1'b0, GAMMA_ADD_HIGH};
  assign adv_hi     = adv_hi_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, adv_hi_sum[WORD_W]};

  // key schedule: position runs backwards for decrypt, last eight positions reverse
  logic [4:0]        key_pos;
  logic [2:0]        key_idx;
  logic [WORD_W-1:0] round_key;
  logic [WORD_W-1:0] round_out;

  assign key_pos   = decrypt ? (LAST_ROUND_FULL - round_cnt) : round_cnt;
  assign key_idx   = (key_pos < REVERSE_START) ? key_pos[2:0] : ~key_pos[2:0];
  assign round_key = key_words[key_idx];
  assign round_out = round_fn(n1, round_key, sbox_rows) ^ n2;

  // output register is free when empty or being drained this cycle
  logic out_free;
  logic result_load;
  assign out_free      = !result_valid || m_axis_tready;
  assign result_load   = (state == ST_FLUSH) && out_free;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = result_valid;
  assign m_axis_tdata  = result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sbox_rows <= '0;
    end else if (cfg_we) begin
      sbox_rows[cfg_index] <= cfg_data;
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      round_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new result replaces the one being drained in the same cycle
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (m_axis_tready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state     <= ST_RUN;
            round_cnt <= '0;
          end
        end
        ST_RUN: begin
          round_cnt <= round_cnt + 5'd1;
          if (round_cnt == last_round) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_words  <= s_axis_tdata[383:128];
          data_block <= in_data;
          decrypt    <= (in_func == FUNC_DECRYPT);
          gamma      <= (in_func == FUNC_GAMMA);
          last_round <= (in_func == FUNC_MAC) ? LAST_ROUND_MAC : LAST_ROUND_FULL;
          if (in_func == FUNC_GAMMA) begin
            n1 <= adv_lo;
            n2 <= adv_hi;
          end else begin
            n1 <= in_data[WORD_W-1:0];
            n2 <= in_data[BLOCK_W-1:WORD_W];
          end
        end
      end
      ST_RUN: begin
        n1 <= round_out;
        n2 <= n1;
      end
      ST_FLUSH: begin
        if (out_free) begin
          // final block: high word n1, low word n2; gamma xors it onto the data
          result <= gamma ? (data_block ^ {n1, n2}) : {n1, n2};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
